>>> hdl/apr_pkg.sv
// types and constants shared by the aging page-replacement block
`timescale 1ns / 1ps

package apr_pkg;

   localparam int REF_W         = 8;
   localparam int PAGE_W        = 8;
   localparam int FRAME_OUT_W   = 3;
   localparam int PERIOD_W      = 8;
   localparam int IN_Q_DEPTH    = 2;
   localparam int OUT_Q_DEPTH   = 2;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd5;

   typedef enum logic {
      ACT_TICK    = 1'b0,
      ACT_REPLACE = 1'b1
   } action_type;

   // classified item handed from front to back
   typedef struct packed {
      action_type         act;
      logic [REF_W-1:0]   ref_bits;
      logic [PAGE_W-1:0]  new_page;
   } cmd_type;

   typedef struct packed {
      logic [FRAME_OUT_W-1:0] victim_frame;
      logic [PAGE_W-1:0]      victim_page;
      logic                   counters_cleared;
   } rsp_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_SCAN = 2'd1,
      ST_DONE = 2'd2
   } back_state_type;

endpackage

>>> hdl/apr_fifo.sv
// small register-based first-in first-out queue
`timescale 1ns / 1ps

module apr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full    = (count_ff == CNT_W'(DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push & ~full;
   assign do_pop  = pop & ~empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      count_in = count_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> hdl/apr_front.sv
// front end: takes items, classifies them and queues them for the back end
`timescale 1ns / 1ps

module apr_front
   import apr_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  logic              req_action,
   input  logic [REF_W-1:0]  req_ref_bits,
   input  logic [PAGE_W-1:0] req_new_page,
   output logic              cmd_valid,
   output cmd_type           cmd,
   input  logic              cmd_pop
);

   cmd_type                     cmd_wr;
   logic [$bits(cmd_type)-1:0]  cmd_rd;
   logic                        cmd_empty;

   // unused field of each kind is zeroed so the back end sees a clean item
   always_comb begin
      cmd_wr.act      = (req_action == 1'b1) ? ACT_REPLACE : ACT_TICK;
      cmd_wr.ref_bits = (req_action == 1'b1) ? '0 : req_ref_bits;
      cmd_wr.new_page = (req_action == 1'b1) ? req_new_page : '0;
   end

   apr_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (IN_Q_DEPTH)
   ) u_cmd_q (
      .clock   (clock),
      .reset   (reset),
      .push    (req_push),
      .wr_data (cmd_wr),
      .full    (req_full),
      .pop     (cmd_pop),
      .rd_data (cmd_rd),
      .empty   (cmd_empty)
   );

   assign cmd_valid = ~cmd_empty;
   assign cmd       = cmd_type'(cmd_rd);

endmodule

>>> hdl/apr_back.sv
// back end: frame state, aging on tick, victim scan and replace on replace
`timescale 1ns / 1ps

module apr_back
   import apr_pkg::*;
#(
   parameter int NUM_FRAMES = 8,
   parameter int AGE_BITS   = 8
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_write,
   input  logic [PERIOD_W-1:0] csr_data,
   input  logic                cmd_valid,
   input  cmd_type             cmd,
   output logic                cmd_pop,
   output logic                rsp_push,
   output rsp_type             rsp,
   input  logic                rsp_full
);

   localparam int IDX_W = $clog2(NUM_FRAMES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_FRAMES - 1);

   logic [AGE_BITS-1:0] age_ff  [NUM_FRAMES];
   logic [PAGE_W-1:0]   page_ff [NUM_FRAMES];

   back_state_type      state_ff, state_in;
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic [IDX_W-1:0]    best_ff, best_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic [PERIOD_W-1:0] count_ff, count_in;
   logic [PERIOD_W-1:0] period_ff;
   logic [PERIOD_W-1:0] count_next;
   logic                clear_all;
   logic                do_tick;
   logic                do_apply;

   assign count_next = count_ff + 1'b1;
   // a period of zero clears on every replacement, as does one
   assign clear_all  = (count_next >= period_ff);

   always_comb begin
      rsp.victim_frame     = FRAME_OUT_W'(best_ff);
      rsp.victim_page      = page_ff[best_ff];
      rsp.counters_cleared = clear_all;
   end

   always_comb begin
      state_in    = state_ff;
      idx_in      = idx_ff;
      best_in     = best_ff;
      best_age_in = best_age_ff;
      count_in    = count_ff;
      cmd_pop     = 1'b0;
      rsp_push    = 1'b0;
      do_tick     = 1'b0;
      do_apply    = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               if (cmd.act == ACT_TICK) begin
                  do_tick = 1'b1;
                  cmd_pop = 1'b1;
               end else begin
                  state_in    = ST_SCAN;
                  idx_in      = '0;
                  best_in     = '0;
                  best_age_in = '1;
               end
            end
         end
         ST_SCAN: begin
            // less-or-equal lets ties move to the higher index
            if (age_ff[idx_ff] <= best_age_ff) begin
               best_in     = idx_ff;
               best_age_in = age_ff[idx_ff];
            end
            if (idx_ff == LAST_IDX) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_full) begin
               do_apply = 1'b1;
               cmd_pop  = 1'b1;
               rsp_push = 1'b1;
               count_in = clear_all ? '0 : count_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         idx_ff      <= '0;
         best_ff     <= '0;
         best_age_ff <= '1;
         count_ff    <= '0;
      end else begin
         state_ff    <= state_in;
         idx_ff      <= idx_in;
         best_ff     <= best_in;
         best_age_ff <= best_age_in;
         count_ff    <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= PERIOD_RESET;
      end else if (csr_write) begin
         period_ff <= csr_data;
      end
   end

   for (genvar f = 0; f < NUM_FRAMES; f++) begin : g_frame
      logic ref_bit;
      if (f < REF_W) begin : g_ref
         assign ref_bit = cmd.ref_bits[f];
      end else begin : g_noref
         assign ref_bit = 1'b0;
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            age_ff[f]  <= '0;
            page_ff[f] <= PAGE_W'(f);
         end else if (do_tick) begin
            age_ff[f] <= {ref_bit, age_ff[f][AGE_BITS-1:1]};
         end else if (do_apply) begin
            if (clear_all || (best_ff == IDX_W'(f))) begin
               age_ff[f] <= '0;
            end
            if (best_ff == IDX_W'(f)) begin
               page_ff[f] <= cmd.new_page;
            end
         end
      end
   end

endmodule

>>> hdl/aging_page_replacement.sv
// aging page replacement: top level joining front end, back end and result queue
// the back end handles one item at a time, while the input queue can take more items; a tick
// is applied in ST_IDLE and gives no item; a replace steps through ST_IDLE, ST_SCAN (one frame
// per scan step) and ST_DONE, which waits while the result queue is full, then queues its result
// reset: synchronous, active high; ages zero, frame f holds page f, period 5, queues empty
`timescale 1ns / 1ps

module aging_page_replacement
   import apr_pkg::*;
#(
   parameter int NUM_FRAMES = 8,
   parameter int AGE_BITS   = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   // item input
   input  logic                   req_push,
   output logic                   req_full,
   input  logic                   req_action,
   input  logic [REF_W-1:0]       req_ref_bits,
   input  logic [PAGE_W-1:0]      req_new_page,
   // result output
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [FRAME_OUT_W-1:0] rsp_victim_frame,
   output logic [PAGE_W-1:0]      rsp_victim_page,
   output logic                   rsp_counters_cleared,
   // clear period register
   input  logic                   csr_write,
   input  logic [PERIOD_W-1:0]    csr_data
);

   // front to back handoff
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // back end to result queue
   rsp_type                    rsp_wr;
   logic                       rsp_push;
   logic                       rsp_full;
   logic [$bits(rsp_type)-1:0] rsp_rd;
   rsp_type                    rsp_head;

   // front: accept and classify items into a short queue
   apr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_push     (req_push),
      .req_full     (req_full),
      .req_action   (req_action),
      .req_ref_bits (req_ref_bits),
      .req_new_page (req_new_page),
      .cmd_valid    (cmd_valid),
      .cmd          (cmd),
      .cmd_pop      (cmd_pop)
   );

   // back: ages, page table, victim scan, periodic clear
   apr_back #(
      .NUM_FRAMES (NUM_FRAMES),
      .AGE_BITS   (AGE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_data  (csr_data),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .rsp_push  (rsp_push),
      .rsp       (rsp_wr),
      .rsp_full  (rsp_full)
   );

   // result queue decouples the back end from the consumer
   apr_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (OUT_Q_DEPTH)
   ) u_rsp_q (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_wr),
      .full    (rsp_full),
      .pop     (rsp_pop),
      .rd_data (rsp_rd),
      .empty   (rsp_empty)
   );

   assign rsp_head             = rsp_type'(rsp_rd);
   assign rsp_victim_frame     = rsp_head.victim_frame;
   assign rsp_victim_page      = rsp_head.victim_page;
   assign rsp_counters_cleared = rsp_head.counters_cleared;

endmodule

>>> hdl/apr_checker.sv
// port-level assertions for the aging page-replacement block, with bind
`timescale 1ns / 1ps

module apr_checker
   import apr_pkg::*;
#(
   parameter int NUM_FRAMES = 8
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_full,
   input logic                   rsp_empty,
   input logic                   rsp_pop,
   input logic [FRAME_OUT_W-1:0] rsp_victim_frame,
   input logic [PAGE_W-1:0]      rsp_victim_page,
   input logic                   rsp_counters_cleared
);

   // reset leaves no result waiting
   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result queue not empty after reset");

   // reset leaves room for input
   a_reset_room: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input queue full after reset");

   // a waiting result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=>
         (!rsp_empty && $stable(rsp_victim_frame) && $stable(rsp_victim_page)
          && $stable(rsp_counters_cleared)))
      else $error("waiting result changed before pop");

   // victim frame lies within the resident frames
   a_frame_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> ((NUM_FRAMES >= 8) || (int'(rsp_victim_frame) < NUM_FRAMES)))
      else $error("victim frame out of range");

endmodule

bind aging_page_replacement apr_checker #(.NUM_FRAMES(NUM_FRAMES)) u_apr_checker (.*);
